### rtl/ber_style_tlv_primitive_encoder_core_assert.svh
// Assertion macros shared by the TLV encoder RTL.
// Included by modules that carry concurrent checks; needs a clk and rst in scope.
`ifndef BER_STYLE_TLV_PRIMITIVE_ENCODER_CORE_ASSERT_SVH
`define BER_STYLE_TLV_PRIMITIVE_ENCODER_CORE_ASSERT_SVH

// Check sampled on clk, masked while rst is high.
`define BERTLV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check sampled on clk, also active during reset.
`define BERTLV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/bertlv_pkg.sv
// Types and constants for the BER-style TLV primitive encoder.
// No dependencies; imported by every module of the block.
package bertlv_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CountW   = 4;

  typedef enum logic [2:0] {
    MODE_BOOL     = 3'd0,
    MODE_INT      = 3'd1,
    MODE_F32      = 3'd2,
    MODE_F64      = 3'd3,
    MODE_STR_HDR  = 3'd4,
    MODE_STR_CHAR = 3'd5
  } mode_t;

  localparam logic [7:0] LEN_LONG1 = 8'h81;
  localparam logic [7:0] LEN_LONG2 = 8'h82;
  localparam logic [7:0] LEN_LONG3 = 8'h83;
  localparam logic [7:0] LEN_BOOL  = 8'h01;
  localparam logic [7:0] LEN_F32   = 8'h04;
  localparam logic [7:0] LEN_F64   = 8'h08;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  tag;
    logic [63:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One classified item: bytes in emission order from index 0.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } job_t;

endpackage

### rtl/ber_style_tlv_primitive_encoder_core.sv
// Channel   Direction  Transfer when          Payload
// item      in         push && !full         bertlv_pkg::in_item_t (mode, tag, data_value)
// result    out        pop && !empty         bertlv_pkg::out_item_t (out_byte, last)
//
// One result byte per cycle while pop is held and bytes are ready; an item has 1 to 10 bytes
// (a double has 10), emitted by the byte serializer in the back end.
// The front classifies in the accepting cycle; up to QDEPTH jobs wait in the
// queue, so push stays open, until the queue is full, while the back end drains or is stalled by pop.
// Reset (rst, synchronous) empties queue and serializer; no clearing pass.
// Modes 6 and 7 are accepted and dropped.
// Top level of the BER-style TLV primitive encoder; uses bertlv_pkg,
// bertlv_front, bertlv_queue and bertlv_back.
module ber_style_tlv_primitive_encoder_core #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  bertlv_pkg::in_item_t  item,
  output logic                  empty,
  input  logic                  pop,
  output bertlv_pkg::out_item_t result
);
  import bertlv_pkg::*;

  logic take;     // item transfer this cycle
  logic wr_en;    // classified job has bytes
  job_t wr_job;
  job_t rd_job;
  logic q_empty;
  logic q_rd;

  assign take = push && !full;

  // Classifier: builds the whole TLV frame in the accept cycle.
  bertlv_front u_front (
    .item  (item),
    .take  (take),
    .wr_en (wr_en),
    .job   (wr_job)
  );

  // Decouples acceptance from byte emission.
  bertlv_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_job (wr_job),
    .full   (full),
    .rd_en  (q_rd),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  // Serializer: result comes straight from its registers.
  bertlv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (rd_job),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

### rtl/bertlv_front.sv
// Front end: classifies an accepted item into a byte frame and count.
// Depends on bertlv_pkg.
module bertlv_front (
  input  bertlv_pkg::in_item_t item,
  input  logic                 take,
  output logic                 wr_en,
  output bertlv_pkg::job_t     job
);
  import bertlv_pkg::*;

  logic [31:0] ival;
  logic [2:0]  isize;
  logic [63:0] len;

  assign ival = item.data_value[31:0];
  assign len  = item.data_value;

  // Fewest two's-complement bytes: top bits uniform means a byte can go.
  always_comb begin
    if ((&ival[31:7]) || !(|ival[31:7])) begin
      isize = 3'd1;
    end else if ((&ival[31:15]) || !(|ival[31:15])) begin
      isize = 3'd2;
    end else if ((&ival[31:23]) || !(|ival[31:23])) begin
      isize = 3'd3;
    end else begin
      isize = 3'd4;
    end
  end

  always_comb begin
    job.bytes    = '0;
    job.count    = '0;
    job.bytes[0] = item.tag;
    unique case (item.mode)
      MODE_BOOL: begin
        job.bytes[1] = LEN_BOOL;
        job.bytes[2] = {7'd0, |item.data_value};
        job.count    = CountW'(3);
      end
      MODE_INT: begin
        job.bytes[1] = {5'd0, isize};
        job.count    = CountW'(2) + CountW'(isize);
        unique case (isize)
          3'd1: job.bytes[2] = ival[7:0];
          3'd2: begin
            job.bytes[2] = ival[15:8];
            job.bytes[3] = ival[7:0];
          end
          3'd3: begin
            job.bytes[2] = ival[23:16];
            job.bytes[3] = ival[15:8];
            job.bytes[4] = ival[7:0];
          end
          default: begin
            job.bytes[2] = ival[31:24];
            job.bytes[3] = ival[23:16];
            job.bytes[4] = ival[15:8];
            job.bytes[5] = ival[7:0];
          end
        endcase
      end
      MODE_F32: begin
        job.bytes[1] = LEN_F32;
        job.bytes[2] = item.data_value[31:24];
        job.bytes[3] = item.data_value[23:16];
        job.bytes[4] = item.data_value[15:8];
        job.bytes[5] = item.data_value[7:0];
        job.count    = CountW'(6);
      end
      MODE_F64: begin
        job.bytes[1] = LEN_F64;
        job.bytes[2] = item.data_value[63:56];
        job.bytes[3] = item.data_value[55:48];
        job.bytes[4] = item.data_value[47:40];
        job.bytes[5] = item.data_value[39:32];
        job.bytes[6] = item.data_value[31:24];
        job.bytes[7] = item.data_value[23:16];
        job.bytes[8] = item.data_value[15:8];
        job.bytes[9] = item.data_value[7:0];
        job.count    = CountW'(10);
      end
      MODE_STR_HDR: begin
        priority if (len < 64'h80) begin
          job.bytes[1] = len[7:0];
          job.count    = CountW'(2);
        end else if (len <= 64'hFF) begin
          job.bytes[1] = LEN_LONG1;
          job.bytes[2] = len[7:0];
          job.count    = CountW'(3);
        end else if (len <= 64'hFFFF) begin
          job.bytes[1] = LEN_LONG2;
          job.bytes[2] = len[15:8];
          job.bytes[3] = len[7:0];
          job.count    = CountW'(4);
        end else if (len <= 64'hFFFFFF) begin
          job.bytes[1] = LEN_LONG3;
          job.bytes[2] = len[23:16];
          job.bytes[3] = len[15:8];
          job.bytes[4] = len[7:0];
          job.count    = CountW'(5);
        end else begin
          // overlong length: tag alone
          job.count = CountW'(1);
        end
      end
      MODE_STR_CHAR: begin
        job.bytes[0] = item.data_value[7:0];
        job.count    = CountW'(1);
      end
      default: begin
        job.count = '0;   // unused modes make nothing
      end
    endcase
  end

  assign wr_en = take && (job.count != '0);

endmodule

### rtl/bertlv_queue.sv
// Short job queue between front and back ends.
// Depends on bertlv_pkg and the assertion header.
module bertlv_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  bertlv_pkg::job_t wr_job,
  output logic             full,
  input  logic             rd_en,
  output bertlv_pkg::job_t rd_job,
  output logic             empty
);
  import bertlv_pkg::*;
  `include "ber_style_tlv_primitive_encoder_core_assert.svh"

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            store [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full   = (fill == CntW'(DEPTH));
  assign empty  = (fill == '0);
  assign rd_job = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `BERTLV_ASSERT(a_no_overflow, wr_en |-> !full, "queue written while full")
  `BERTLV_ASSERT(a_no_underflow, rd_en |-> !empty, "queue read while empty")
  `BERTLV_ASSERT(a_fill_range, fill <= CntW'(DEPTH), "queue fill out of range")

endmodule

### rtl/bertlv_back.sv
// Back end: serializes one job a byte at a time into the result register.
// Depends on bertlv_pkg and the assertion header.
module bertlv_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bertlv_pkg::job_t      job,
  input  logic                  q_empty,
  output logic                  q_rd,
  output bertlv_pkg::out_item_t result,
  output logic                  empty,
  input  logic                  pop
);
  import bertlv_pkg::*;
  `include "ber_style_tlv_primitive_encoder_core_assert.svh"

  logic [MaxBytes-1:0][7:0] bytes;
  logic [CountW-1:0]        rem;
  logic                     done;
  logic                     take;

  assign empty           = (rem == '0);
  assign take            = pop && !empty;
  assign done            = empty || (take && rem == CountW'(1));
  assign q_rd            = done && !q_empty;
  assign result.out_byte = bytes[0];
  assign result.last     = (rem == CountW'(1));

  always_ff @(posedge clk) begin
    if (q_rd) begin
      bytes <= job.bytes;
    end else if (take) begin
      bytes <= bytes >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (q_rd) begin
      rem <= job.count;
    end else if (take) begin
      rem <= rem - 1'b1;
    end
  end

  `BERTLV_ASSERT(a_rem_range, rem <= CountW'(MaxBytes), "byte count out of range")
  `BERTLV_ASSERT(a_drain, (take && result.last && q_empty) |=> empty,
                 "result left after final byte")
  `BERTLV_ASSERT(a_load_nonzero, q_rd |=> !empty, "empty job loaded")

endmodule

### dv/ber_style_tlv_primitive_encoder_core_tb.sv
// Testbench for ber_style_tlv_primitive_encoder_core: random and directed primitives in,
// TLV byte stream out, checked against an in-bench encoder of the BER header and value.
// Depends on bertlv_pkg and the core RTL only.
module ber_style_tlv_primitive_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bertlv_pkg::*;

  // Modes that the core accepts and drops.
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  // Tracks the TLV bytes still owed by the core and checks each one as it leaves.
  class tlv_stream_check;
    out_item_t   bytes_due[$];
    logic [7:0]  encoded[$];
    int unsigned errors;

    function void put_header(logic [7:0] tag, logic [63:0] len);
      encoded.push_back(tag);
      if (len < 64'h80) begin
        encoded.push_back(len[7:0]);
      end else if (len <= 64'hFF) begin
        encoded.push_back(LEN_LONG1);
        encoded.push_back(len[7:0]);
      end else if (len <= 64'hFFFF) begin
        encoded.push_back(LEN_LONG2);
        encoded.push_back(len[15:8]);
        encoded.push_back(len[7:0]);
      end else if (len <= 64'hFF_FFFF) begin
        encoded.push_back(LEN_LONG3);
        encoded.push_back(len[23:16]);
        encoded.push_back(len[15:8]);
        encoded.push_back(len[7:0]);
      end
      // overlong string length: tag byte alone
    endfunction

    // Encode one accepted primitive and queue its bytes, last flag on the final one.
    function void note_item(in_item_t it);
      logic [31:0] v;
      int unsigned n;
      out_item_t   ob;
      encoded.delete();
      case (it.mode)
        MODE_BOOL: begin
          put_header(it.tag, 64'(LEN_BOOL));
          encoded.push_back((it.data_value != 64'd0) ? 8'h01 : 8'h00);
        end
        MODE_INT: begin
          // strip redundant sign bytes: top 9 bits all equal means the lead byte adds nothing
          v = it.data_value[31:0];
          n = 4;
          while (n > 1 && (v[31:23] == 9'h000 || v[31:23] == 9'h1FF)) begin
            n--;
            v = v << 8;
          end
          put_header(it.tag, 64'(n));
          for (int i = 0; i < n; i++) begin
            encoded.push_back(v[31:24]);
            v = v << 8;
          end
        end
        MODE_F32: begin
          put_header(it.tag, 64'(LEN_F32));
          for (int i = 3; i >= 0; i--) encoded.push_back(it.data_value[8*i +: 8]);
        end
        MODE_F64: begin
          put_header(it.tag, 64'(LEN_F64));
          for (int i = 7; i >= 0; i--) encoded.push_back(it.data_value[8*i +: 8]);
        end
        MODE_STR_HDR: put_header(it.tag, it.data_value);
        MODE_STR_CHAR: encoded.push_back(it.data_value[7:0]);
        default: ;
      endcase
      foreach (encoded[i]) begin
        ob.out_byte = encoded[i];
        ob.last     = (i == encoded.size() - 1);
        bytes_due.push_back(ob);
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t exp;
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, actual byte %02h last %0b",
                 $time, got.out_byte, got.last);
        return;
      end
      exp = bytes_due.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                 $time, exp.out_byte, got.out_byte);
      end
      if (got.last !== exp.last) begin
        errors++;
        $display("%0t: last mismatch on byte %02h, expected %0b, actual %0b",
                 $time, exp.out_byte, exp.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return bytes_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst    = 1'b1;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  in_item_t  item_d = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  // Idle-free stretches for each side, switched between phases.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  tlv_stream_check sb = new();

  ber_style_tlv_primitive_encoder_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item_d),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Both transfer kinds are seen with pre-edge values, so ordering within the step is moot.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_item(item_d);
      if (pop && !empty) sb.check_byte(result);
    end
  end

  // Result side: random hold before each pop, none while rx_calm is set.
  initial begin : result_sink
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        pop <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Leaves push high after the transfer so that back-to-back items need no second assignment.
  task automatic send(input in_item_t x);
    int unsigned hold;
    hold = tx_calm ? 0 : $urandom_range(0, 14);
    if (hold != 0) begin
      push <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    push   <= 1'b1;
    item_d <= x;
    do @(posedge clk); while (full);
  endtask

  // Sender holds off until every owed byte has been popped; the first edge lets the
  // monitor note the item transferred at the edge the caller returned from.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [2:0] m, logic [7:0] tag, logic [63:0] data);
    in_item_t it;
    it.mode       = m;
    it.tag        = tag;
    it.data_value = data;
    return it;
  endfunction

  // Random content shaped per mode so every integer size and length form shows up.
  function automatic in_item_t random_item(logic [2:0] m);
    logic [63:0] data;
    int signed   s;
    int unsigned k;
    data = {$urandom, $urandom};
    case (m)
      MODE_BOOL: if ($urandom_range(0, 2) == 0) data = 64'd0;
      MODE_INT: begin
        s = $urandom;
        k = $urandom_range(1, 4);
        s = (s <<< (32 - 8 * k)) >>> (32 - 8 * k);
        data[31:0] = s;
      end
      MODE_STR_HDR: begin
        case ($urandom_range(0, 4))
          0: data = 64'($urandom_range(0, 8'h7F));
          1: data = 64'($urandom_range(8'h80, 8'hFF));
          2: data = 64'($urandom_range(16'h100, 16'hFFFF));
          3: data = 64'($urandom_range(24'h1_0000, 24'hFF_FFFF));
          default: data[24 + $urandom_range(0, 39)] = 1'b1;  // past three length bytes
        endcase
      end
      default: ;
    endcase
    return mk(m, 8'($urandom_range(0, 255)), data);
  endfunction

  initial begin : stimulus
    in_item_t    directed[$];
    int unsigned done_items;
    int unsigned next_shift;
    int unsigned pick;
    int unsigned nchar;
    bit          paused;
    logic [7:0]  tag;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, each mode, integer size edges, each length form,
    // an overlong string length, character with tag ignored, and the dropped modes.
    directed.push_back(mk(MODE_BOOL, 8'h00, 64'd0));
    directed.push_back(mk(MODE_BOOL, 8'hFF, 64'h8000_0000_0000_0000));
    directed.push_back(mk(MODE_INT, 8'h02, 64'd0));
    directed.push_back(mk(MODE_INT, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(mk(MODE_INT, 8'h02, 64'h0000_0000_0000_007F));
    directed.push_back(mk(MODE_INT, 8'h02, 64'h0000_0000_0000_0080));
    directed.push_back(mk(MODE_INT, 8'h02, 64'h0000_0000_FFFF_FF80));
    directed.push_back(mk(MODE_INT, 8'h02, 64'h0000_0000_FFFF_FF7F));
    directed.push_back(mk(MODE_INT, 8'h02, 64'hA5A5_A5A5_7FFF_FFFF));
    directed.push_back(mk(MODE_INT, 8'h02, 64'h0000_0000_8000_0000));
    directed.push_back(mk(MODE_F32, 8'h09, 64'hDEAD_BEEF_3F80_0000));
    directed.push_back(mk(MODE_F64, 8'h09, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(mk(MODE_F64, 8'h00, 64'h0123_4567_89AB_CDEF));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'd0));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'h7F));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'h80));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'hFF));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'h100));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'hFFFF));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'h1_0000));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'hFF_FFFF));
    directed.push_back(mk(MODE_STR_HDR, 8'hFF, 64'h100_0000));
    directed.push_back(mk(MODE_STR_HDR, 8'h0C, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(mk(MODE_STR_CHAR, 8'hFF, 64'hFFFF_FFFF_FFFF_FF41));
    directed.push_back(mk(MODE_SPARE6, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(mk(MODE_SPARE7, 8'h00, 64'h0));
    foreach (directed[i]) send(directed[i]);

    // Hold-off with everything drained before random traffic starts.
    wait_drained();

    done_items = 0;
    next_shift = 0;
    paused     = 1'b0;
    while (done_items < 90) begin
      if (done_items >= next_shift) begin
        tx_calm    = ($urandom_range(0, 3) == 0);
        rx_calm    = ($urandom_range(0, 3) == 0);
        next_shift += 30;
      end
      if (!paused && done_items >= 45) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        // well-formed string: short header, then one character per byte of length
        nchar = $urandom_range(0, 6);
        tag   = 8'($urandom_range(0, 255));
        send(mk(MODE_STR_HDR, tag, 64'(nchar)));
        done_items++;
        repeat (nchar) begin
          send(random_item(MODE_STR_CHAR));
          done_items++;
        end
      end else if (pick < 9) begin
        send(random_item(3'($urandom_range(MODE_BOOL, MODE_STR_CHAR))));
        done_items++;
      end else begin
        // noise: dropped modes, not counted
        send(random_item(($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7));
      end
    end

    wait_drained();
    // room for any stray byte after the last one owed
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ber_style_tlv_primitive_encoder_core_tb: done, clean");
    end else begin
      $display("ber_style_tlv_primitive_encoder_core_tb: done, errors");
    end
    $finish;
  end

  // Timeout set many times above a worst-case run: every item at full length with the longest random holds.
  initial begin : watchdog
    #5_000_000;
    $display("ber_style_tlv_primitive_encoder_core_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bertlv_pkg.sv
rtl/bertlv_front.sv
rtl/bertlv_queue.sv
rtl/bertlv_back.sv
rtl/ber_style_tlv_primitive_encoder_core.sv
dv/ber_style_tlv_primitive_encoder_core_tb.sv
